// ===== rtl/core/brle_pkg.sv =====
// Package for the byte run-length decoder.
// Widths, result item type, phase codes, reset cap and repeat bias; no dependencies.
package brle_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned TotalW = 16;
  localparam int unsigned LitW   = 7;

  localparam logic [TotalW-1:0] CapReset  = 16'd40960;
  localparam logic [ByteW-1:0]  RepBias   = 8'd127;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_LITERAL = 3'b010,
    PH_REPEAT  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0]  value;
    logic [CountW-1:0] count;
    logic              final_flag;
    logic [TotalW-1:0] total;
  } result_t;

endpackage

// ===== rtl/core/byte_rle_decoder.sv =====
// Top level of the byte run-length decoder.
// Instantiates brle_decode and brle_outbuf; depends on brle_pkg.
// Takes one compressed byte per cycle while in_stall is low; results are
// registered. The decode step is a single registered pass over the chunk
// state, and a skid entry behind the result register takes one result while
// the output stalls. A result carries a run (value, count) and, on the chunk's
// last byte, the final flag and decoded total. The cap applies per chunk.
module byte_rle_decoder import brle_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [TotalW-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ByteW-1:0]  in_byte,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ByteW-1:0]  out_byte,
  output logic [CountW-1:0] out_count,
  output logic              out_final,
  output logic [TotalW-1:0] out_total
);

  logic    take;
  logic    emit;
  logic    full;
  result_t res;
  result_t out_data;

  assign in_stall = full;
  assign take     = in_valid && !full;

  brle_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .take    (take),
    .in_byte (in_byte),
    .in_last (in_last),
    .emit    (emit),
    .res     (res)
  );

  brle_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (take && emit),
    .push_data(res),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  assign out_byte  = out_data.value;
  assign out_count = out_data.count;
  assign out_final = out_data.final_flag;
  assign out_total = out_data.total;

endmodule

// ===== rtl/core/brle_decode.sv =====
// Chunk state, output cap register and per-byte decode step.
// Depends on brle_pkg.
module brle_decode import brle_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [TotalW-1:0] cfg_data,
  input  logic              take,
  input  logic [ByteW-1:0]  in_byte,
  input  logic              in_last,
  output logic              emit,
  output result_t           res
);

  phase_t            phase_r, phase_nxt;
  logic [LitW-1:0]   lit_left_r, lit_left_nxt;
  logic [CountW-1:0] rep_len_r, rep_len_nxt;
  logic [TotalW-1:0] produced_r, produced_nxt;
  logic [TotalW-1:0] cap_r;
  logic [TotalW-1:0] room;
  logic [CountW-1:0] cnt;

  assign room = cap_r - produced_r;

  always_comb begin
    phase_nxt    = phase_r;
    lit_left_nxt = lit_left_r;
    rep_len_nxt  = rep_len_r;
    produced_nxt = produced_r;
    cnt          = '0;
    if (produced_r < cap_r) begin
      case (phase_r)
        PH_LITERAL: begin
          cnt          = CountW'(1);
          produced_nxt = produced_r + TotalW'(1);
          lit_left_nxt = lit_left_r - LitW'(1);
          if (lit_left_nxt == '0) begin
            phase_nxt = PH_HEADER;
          end
        end
        PH_REPEAT: begin
          if (TotalW'(rep_len_r) > room) begin
            cnt = room[CountW-1:0];
          end else begin
            cnt = rep_len_r;
          end
          produced_nxt = produced_r + TotalW'(cnt);
          phase_nxt    = PH_HEADER;
        end
        default: begin
          if (!in_byte[ByteW-1]) begin
            lit_left_nxt = in_byte[LitW-1:0];
            phase_nxt    = (in_byte != '0) ? PH_LITERAL : PH_HEADER;
          end else begin
            rep_len_nxt = in_byte - RepBias;
            phase_nxt   = PH_REPEAT;
          end
        end
      endcase
    end
    emit           = (cnt != '0) || in_last;
    res.value      = (cnt != '0) ? in_byte : '0;
    res.count      = cnt;
    res.final_flag = in_last;
    res.total      = in_last ? produced_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CapReset;
    end else if (cfg_we) begin
      cap_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      lit_left_r <= '0;
      rep_len_r  <= '0;
      produced_r <= '0;
    end else if (take) begin
      if (in_last) begin
        phase_r    <= PH_HEADER;
        lit_left_r <= '0;
        rep_len_r  <= '0;
        produced_r <= '0;
      end else begin
        phase_r    <= phase_nxt;
        lit_left_r <= lit_left_nxt;
        rep_len_r  <= rep_len_nxt;
        produced_r <= produced_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/brle_outbuf.sv =====
// Result register with one skid entry between decode step and output channel.
// Depends on brle_pkg.
module brle_outbuf import brle_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_data_r;
  result_t skid_data_r;
  logic    out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

// ===== sim/brle_monitor.sv =====
// Checker for the byte run-length decoder: watches the config port and both item channels.
// Keeps its own copy of the chunk state, queues the runs it expects and compares them.
// Depends on brle_pkg for the phase and result types.
module brle_monitor import brle_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [TotalW-1:0] cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [ByteW-1:0]  in_byte,
  input  logic              in_last,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [ByteW-1:0]  out_byte,
  input  logic [CountW-1:0] out_count,
  input  logic              out_final,
  input  logic [TotalW-1:0] out_total,
  output int                fail_count,
  output int                pending,
  output int                runs_checked,
  output int                chunk_ends
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [TotalW-1:0] cap;
  phase_t            dec_phase;
  logic [LitW-1:0]   lit_left;
  logic [CountW-1:0] rep_len;
  logic [TotalW-1:0] produced;
  result_t           runs_due[$];
  result_t           want;

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("run %0d %s got %0d want %0d", runs_checked, name,
                                got, exp_val));
  endtask

  task automatic clear_chunk();
    dec_phase = PH_HEADER;
    lit_left  = '0;
    rep_len   = '0;
    produced  = '0;
  endtask

  task automatic decode_step(input logic [ByteW-1:0] b, input logic last);
    result_t           r;
    logic [TotalW-1:0] room;
    logic [CountW-1:0] n;
    r = '0;
    if (produced < cap) begin
      case (dec_phase)
        PH_LITERAL: begin
          r.value  = b;
          r.count  = 8'd1;
          produced = produced + 16'd1;
          lit_left = lit_left - 7'd1;
          if (lit_left == '0) dec_phase = PH_HEADER;
        end
        PH_REPEAT: begin
          room     = cap - produced;
          n        = (TotalW'(rep_len) > room) ? room[CountW-1:0] : rep_len;
          r.value  = b;
          r.count  = n;
          produced = produced + TotalW'(n);
          dec_phase = PH_HEADER;
        end
        default: begin
          if (b < 8'd128) begin
            lit_left  = b[LitW-1:0];
            dec_phase = (b != '0) ? PH_LITERAL : PH_HEADER;
          end else begin
            rep_len   = b - RepBias;
            dec_phase = PH_REPEAT;
          end
        end
      endcase
    end
    if (r.count != '0 || last) begin
      r.final_flag = last;
      r.total      = last ? produced : '0;
      runs_due.push_back(r);
    end
    if (last) clear_chunk();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cap = CapReset;
      clear_chunk();
      runs_due.delete();
    end else begin
      if (cfg_we) cap = cfg_data;
      if (out_valid && !out_stall) begin
        if (runs_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected (byte %0d count %0d)",
                                    out_byte, out_count));
        end else begin
          want = runs_due.pop_front();
          check_field("out_byte", 16'(out_byte), 16'(want.value));
          check_field("out_count", 16'(out_count), 16'(want.count));
          check_field("out_final", 16'(out_final), 16'(want.final_flag));
          check_field("out_total", out_total, want.total);
          runs_checked++;
          if (want.final_flag) chunk_ends++;
        end
      end
      if (in_valid && !in_stall) begin
        decode_step(in_byte, in_last);
      end
    end
    pending = runs_due.size();
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the byte run-length decoder bench: clock, reset, cap writes and chunk stimulus.
// Instantiates byte_rle_decoder and brle_monitor; depends on brle_pkg.
// Runs a directed set of chunks, then random chunks under three idle patterns.
module testbench;
  import brle_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [TotalW-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [ByteW-1:0]  in_byte;
  logic              in_last;
  logic              out_valid;
  logic              out_stall;
  logic [ByteW-1:0]  out_byte;
  logic [CountW-1:0] out_count;
  logic              out_final;
  logic [TotalW-1:0] out_total;
  int                fail_count;
  int                pending;
  int                runs_checked;
  int                chunk_ends;

  int                send_gap_pct;
  int                recv_stall_pct;
  int                items_sent;
  int                chunks_sent;
  int                cap_writes;
  int unsigned       cycle_count;

  byte_rle_decoder dut (.*);
  brle_monitor monitor_i (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clk);
    $display("[byte_rle_decoder] ERROR");
    $finish;
  end

  task automatic send_item(input logic [ByteW-1:0] b, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    in_last  = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (last) chunks_sent++;
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cap(input logic [TotalW-1:0] value);
    wait_idle();
    cfg_we   = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we   = 1'b0;
    cap_writes++;
  endtask

  function automatic logic [TotalW-1:0] pick_cap();
    case ($urandom_range(5))
      0:       return 16'd1;
      1:       return 16'($urandom_range(2, 16));
      2:       return 16'($urandom_range(17, 300));
      3:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // mostly well-formed chunks, some cut short, some pure noise
  task automatic send_chunk();
    logic [ByteW-1:0] bytes[$];
    int               packets;
    int               kind;
    int               n;
    int               keep;
    if ($urandom_range(99) < 6) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) bytes.push_back(8'($urandom));
    end else begin
      packets = $urandom_range(1, 6);
      for (int p = 0; p < packets; p++) begin
        kind = $urandom_range(99);
        if (kind < 5) begin
          bytes.push_back(8'd0);
        end else if (kind < 50) begin
          n = (kind < 10) ? $urandom_range(7, 127) : $urandom_range(1, 6);
          bytes.push_back(8'(n));
          for (int i = 0; i < n; i++) bytes.push_back(8'($urandom));
        end else begin
          bytes.push_back(8'($urandom_range(128, 255)));
          bytes.push_back(8'($urandom));
        end
      end
      if ($urandom_range(99) < 12) begin
        keep = $urandom_range(1, bytes.size());
        while (bytes.size() > keep) void'(bytes.pop_back());
      end
    end
    foreach (bytes[i]) send_item(bytes[i], i == bytes.size() - 1);
  endtask

  initial begin
    int phase_goal;
    int seg_goal;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_byte        = '0;
    in_last        = 1'b0;
    send_gap_pct   = 27;
    recv_stall_pct = 49;
    items_sent     = 0;
    chunks_sent    = 0;
    cap_writes     = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset cap: zero header, literal, longest and shortest repeat, final with a run
    send_item(8'h00, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hAA, 1'b1);
    // chunk ends on a repeat header, then inside literals
    send_item(8'h85, 1'b1);
    send_item(8'h03, 1'b0);
    send_item(8'h55, 1'b0);
    send_item(8'h12, 1'b1);
    // cap of one: repeat clipped, rest ignored
    write_cap(16'd1);
    send_item(8'h90, 1'b0);
    send_item(8'h33, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h44, 1'b0);
    send_item(8'h00, 1'b1);
    write_cap(16'hFFFF);
    send_item(8'h02, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct   = (ph == 0) ? 27 : (ph == 1) ? 49 : 0;
      recv_stall_pct = (ph == 0) ? 49 : (ph == 1) ? 27 : 0;
      phase_goal = items_sent + 370;
      while (items_sent < phase_goal) begin
        write_cap(pick_cap());
        seg_goal = items_sent + $urandom_range(60, 120);
        while (items_sent < seg_goal && items_sent < phase_goal) send_chunk();
      end
    end

    wait_idle();
    repeat (10) @(negedge clk);
    $display("Sent %0d items in %0d chunks over %0d cap settings (1 and 65535 included).",
             items_sent, chunks_sent, cap_writes + 1);
    $display("Checked %0d runs, %0d of them chunk ends, under three stall patterns.",
             runs_checked, chunk_ends);
    if (fail_count == 0) begin
      $display("[byte_rle_decoder] OK");
    end else begin
      $display("[byte_rle_decoder] ERROR");
    end
    $finish;
  end

endmodule
